[hdl/bira_pkg.sv]
// Shared types and constants of the beat interval rate averager.
`timescale 1ns / 1ps
`default_nettype none

package bira_pkg;

   // Shared divider operand widths
   localparam int DIV_W     = 16;
   localparam int DIVISOR_W = 32;

   // Numerator of the rate: milliseconds per minute
   localparam logic [DIV_W-1:0] RATE_NUMERATOR = 16'd60000;

   // Register indexes and reset values
   localparam logic [7:0] CSR_RATE_FLOOR   = 8'd0;
   localparam logic [7:0] CSR_RATE_CEILING = 8'd1;
   localparam logic [7:0] RATE_FLOOR_RESET   = 8'd20;
   localparam logic [7:0] RATE_CEILING_RESET = 8'd250;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_RATE,
      ST_RING_WR,
      ST_AVG_START,
      ST_DIV_AVG,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_sts_type;

endpackage

`default_nettype wire

[hdl/beat_interval_rate_averager.sv]
// Top level: beat interval to rate, range check and ring average.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata[31:0] beat_time
//  rsp     | out | rsp_tvalid/tready    | tdata[7:0] average_rate, [15:8] instant_rate;
//          |     |                      | tuser[0] rate_accepted
//  csr     | in  | csr_valid/csr_ready  | csr_index (0 floor, 1 ceiling), csr_data
//
//  Each beat runs the shared 16-step divider once for the rate and, when its
//  rate is stored, once more for the ring mean; a rejected rate skips the ring.
//  Reset is synchronous and clears the ring, its slot, the held average and
//  the previous beat time, and loads the default bounds.
//  req_tready is high only while the sequencer idles; a finished word waits in
//  the output register for rsp_tready and the next beat can be taken meanwhile.
//  csr writes are taken whenever reset is low.
`timescale 1ns / 1ps
`default_nettype none

module beat_interval_rate_averager
   import bira_pkg::*;
#(
   parameter int RING_DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // beat_time[31:0]
   input  wire logic [31:0] req_tdata,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // average_rate[7:0], instant_rate[15:8]
   output      logic [15:0] rsp_tdata,
   // rate_accepted[0]
   output      logic [0:0]  rsp_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [7:0]  csr_data,
   input  wire logic        csr_valid,
   output      logic        csr_ready
);

   seq_state_type state_ff, state_in;

   logic [7:0]           floor_ff;
   logic [7:0]           ceiling_ff;
   logic [31:0]          prev_ff;
   logic [31:0]          interval_ff;
   logic                 lo_ok_ff;
   logic                 hi_ok_ff;
   logic [DIV_W-1:0]     rate_ff;
   logic [7:0]           avg_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic                 rsp_user_ff;
   logic [39:0]          prod;
   logic [7:0]           mul_bound;
   logic [7:0]           shown;
   logic [DIV_W-1:0]     ring_sum;
   logic                 ring_wr;
   logic                 rsp_load;
   div_cmd_type          div_cmd;
   div_sts_type          div_sts;

   bira_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .sts   (div_sts)
   );

   bira_ring #(
      .RING_DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_rate (rate_ff[7:0]),
      .sum     (ring_sum)
   );

   // One multiplier serves both bound tests, floor first
   assign mul_bound = (state_ff == ST_MUL_LO) ? floor_ff : ceiling_ff;
   assign prod      = 40'(mul_bound) * 40'(interval_ff);

   // Saturate the displayed rate; a zero interval divides to all ones
   assign shown = (rate_ff > DIV_W'(255)) ? 8'hFF : rate_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in         = state_ff;
      req_tready       = 1'b0;
      ring_wr          = 1'b0;
      rsp_load         = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = RATE_NUMERATOR;
      div_cmd.divisor  = interval_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // Take no beat while reset is held
            req_tready = !reset;
            if (req_tvalid) begin
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            div_cmd.start = 1'b1;
            state_in      = ST_DIV_RATE;
         end
         ST_DIV_RATE: begin
            if (div_sts.done) begin
               state_in = (lo_ok_ff && hi_ok_ff) ? ST_RING_WR : ST_FINISH;
            end
         end
         ST_RING_WR: begin
            ring_wr  = 1'b1;
            state_in = ST_AVG_START;
         end
         ST_AVG_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = ring_sum;
            div_cmd.divisor  = DIVISOR_W'(RING_DEPTH);
            state_in         = ST_DIV_AVG;
         end
         ST_DIV_AVG: begin
            if (div_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= RATE_FLOOR_RESET;
         ceiling_ff <= RATE_CEILING_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_RATE_FLOOR) begin
            floor_ff <= csr_data;
         end else if (csr_index == CSR_RATE_CEILING) begin
            ceiling_ff <= csr_data;
         end
      end
   end

   // Beat time and held average are state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         avg_ff  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            prev_ff <= req_tdata;
         end
         if (state_ff == ST_DIV_AVG && div_sts.done) begin
            avg_ff <= div_sts.quotient[7:0];
         end
      end
   end

   // Working registers of one beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         interval_ff <= req_tdata - prev_ff;
      end
      if (state_ff == ST_MUL_LO) begin
         lo_ok_ff <= (prod < 40'(RATE_NUMERATOR));
      end
      if (state_ff == ST_MUL_HI) begin
         hi_ok_ff <= (prod > 40'(RATE_NUMERATOR));
      end
      if (state_ff == ST_DIV_RATE && div_sts.done) begin
         rate_ff <= div_sts.quotient;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {shown, avg_ff};
         rsp_user_ff <= lo_ok_ff && hi_ok_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign csr_ready  = !reset;

`ifndef NO_ASSERTIONS
   // A stored rate lies within the bounds in force
   a_accepted_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         rsp_tdata[15:8] >= floor_ff && rsp_tdata[15:8] < ceiling_ff)
      else $error("accepted rate outside bounds");

   // The divider reports only while the sequencer waits on it
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == ST_DIV_RATE || state_ff == ST_DIV_AVG)
      else $error("divider done outside a wait state");

   // The divider is never restarted mid-division
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_cmd.start |-> !div_sts.busy)
      else $error("divider started while busy");

   // An accepted beat starts the bound tests next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == ST_MUL_LO)
      else $error("accepted beat did not start");
`endif

endmodule

`default_nettype wire

[hdl/bira_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bira_divider
   import bira_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_cmd_type cmd,
   output div_sts_type      sts
);

   localparam int CNT_W = $clog2(DIV_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     rem_in;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] div_ff;
   logic [DIV_W:0]       trial;
   logic                 q_bit;

   // Bring down the next dividend bit and try the subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      q_bit = (DIVISOR_W'(trial) >= div_ff);
      if (q_bit) begin
         rem_in = DIV_W'(DIVISOR_W'(trial) - div_ff);
      end else begin
         rem_in = trial[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= cmd.dividend;
            div_ff  <= cmd.divisor;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_W-2:0], q_bit};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

`default_nettype wire

[hdl/bira_ring.sv]
// Ring of accepted rates with a running sum of its entries.
`timescale 1ns / 1ps
`default_nettype none

module bira_ring
   import bira_pkg::*;
#(
   parameter int RING_DEPTH = 4
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [7:0]       wr_rate,
   output      logic [DIV_W-1:0] sum
);

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int SUM_W  = $clog2(RING_DEPTH * 255 + 1);

   logic [7:0]        ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0] slot_ff;
   logic [SUM_W-1:0]  sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (wr_en) begin
         // Drop the overwritten entry from the sum, add the new one
         ring_ff[slot_ff] <= wr_rate;
         sum_ff <= sum_ff - SUM_W'(ring_ff[slot_ff]) + SUM_W'(wr_rate);
         if (slot_ff == SLOT_W'(RING_DEPTH - 1)) begin
            slot_ff <= '0;
         end else begin
            slot_ff <= slot_ff + 1'b1;
         end
      end
   end

   assign sum = DIV_W'(sum_ff);

endmodule

`default_nettype wire

[dv/beat_interval_rate_averager_test.sv]
// Self-checking testbench for the beat interval rate averager.
`timescale 1ns / 1ps

module beat_interval_rate_averager_test;
   import bira_pkg::*;

   localparam int RING_N          = 4;
   localparam int SETTLE_CYCLES   = 50;
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moved anywhere
   localparam int PRESSURE_CYCLES = 300;
   // no register lives at this index; writes to it must be dropped
   localparam logic [7:0] CSR_SPARE = 8'd2;

   typedef struct packed {
      logic [7:0] average;
      logic       accepted;
      logic [7:0] instant;
   } rate_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;

   beat_interval_rate_averager #(
      .RING_DEPTH(RING_N)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),   // beat_time[31:0]
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),   // average_rate[7:0], instant_rate[15:8]
      .rsp_tuser  (rsp_tuser),   // rate_accepted[0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Rate predictor: own copy of bounds, beat time, ring and average
   // ---------------------------------------------------------------
   logic [7:0]  floor_bpm;
   logic [7:0]  ceiling_bpm;
   logic [31:0] last_beat;
   logic [7:0]  rate_ring [RING_N];
   int          ring_slot;
   logic [7:0]  held_avg;

   logic [31:0]   beat_times_q [$];   // beats waiting for the driver
   rate_word_type expected_rates [$]; // predicted words waiting for the block
   logic [31:0]   gen_prev;           // last beat time queued by the stimulus
   int            errors = 0;
   bit            steady = 1'b0;      // no random gaps or stalls on either side
   bit            hold_req = 1'b0;    // ask the receiver for a long hold-off

   function automatic rate_word_type predict_beat(logic [31:0] now);
      logic [31:0]   interval;
      logic [63:0]   lo_prod;
      logic [63:0]   hi_prod;
      logic [31:0]   rate;
      int unsigned   sum;
      rate_word_type w;
      interval = now - last_beat;
      last_beat = now;
      lo_prod = 64'(floor_bpm) * 64'(interval);
      hi_prod = 64'(ceiling_bpm) * 64'(interval);
      // a zero interval means an unbounded rate
      rate = (interval == 32'd0) ? 32'hFFFF_FFFF : {16'd0, RATE_NUMERATOR} / interval;
      w.instant = (rate > 32'd255) ? 8'hFF : rate[7:0];
      w.accepted = 1'b0;
      // exact bound tests: floor < 60000/interval < ceiling
      if (lo_prod < 64'(RATE_NUMERATOR) && hi_prod > 64'(RATE_NUMERATOR)) begin
         rate_ring[ring_slot] = rate[7:0];
         ring_slot = (ring_slot + 1) % RING_N;
         sum = 0;
         foreach (rate_ring[k]) sum += rate_ring[k];
         held_avg = 8'(sum / RING_N);
         w.accepted = 1'b1;
      end
      w.average = held_avg;
      return w;
   endfunction

   // ---------------------------------------------------------------
   // Beat stimulus generation
   // ---------------------------------------------------------------
   function automatic logic [31:0] next_beat_time(logic [31:0] prev);
      int unsigned pick;
      int unsigned edge_bpm;
      pick = $urandom_range(0, 99);
      edge_bpm = $urandom_range(0, 1) ? floor_bpm : ceiling_bpm;
      if (edge_bpm == 0) edge_bpm = 1;
      if (pick < 68) return prev + $urandom_range(240, 3000);      // plausible pulse
      else if (pick < 76) return prev + $urandom_range(0, 239);    // too fast
      else if (pick < 84) return prev + $urandom_range(3001, 70000); // too slow
      else if (pick < 94)
         // land right on a bound, one ms either side
         return prev + 60000 / edge_bpm + $urandom_range(0, 2) - 1;
      else return $urandom();                                      // noise
   endfunction

   task automatic queue_at(logic [31:0] t);
      gen_prev = t;
      beat_times_q.push_back(t);
   endtask

   task automatic queue_after(logic [31:0] delta);
      queue_at(gen_prev + delta);
   endtask

   task automatic queue_random(int count);
      repeat (count) queue_at(next_beat_time(gen_prev));
   endtask

   function automatic int pick_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (steady || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // ---------------------------------------------------------------
   // Beat driver: feed words from the queue, predict on acceptance
   // ---------------------------------------------------------------
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rates.push_back(predict_beat(req_tdata));
         // hold the word while it is offered and not taken
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (beat_times_q.size() > 0) begin
               req_tdata <= beat_times_q.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Rate monitor: check each word against the oldest prediction
   // ---------------------------------------------------------------
   int            stall_left = 0;
   rate_word_type got_word;
   rate_word_type want_word;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_word.average = rsp_tdata[7:0];
            got_word.instant = rsp_tdata[15:8];
            got_word.accepted = rsp_tuser[0];
            if (expected_rates.size() == 0) begin
               $display("%0t: unexpected word: average %0d accepted %0d instant %0d",
                        $time, got_word.average, got_word.accepted, got_word.instant);
               errors++;
            end else begin
               want_word = expected_rates.pop_front();
               if (got_word.average !== want_word.average) begin
                  $display("%0t: average_rate expected %0d actual %0d",
                           $time, want_word.average, got_word.average);
                  errors++;
               end
               if (got_word.accepted !== want_word.accepted) begin
                  $display("%0t: rate_accepted expected %0d actual %0d",
                           $time, want_word.accepted, got_word.accepted);
                  errors++;
               end
               if (got_word.instant !== want_word.instant) begin
                  $display("%0t: instant_rate expected %0d actual %0d",
                           $time, want_word.instant, got_word.instant);
                  errors++;
               end
            end
         end
         // drop ready for a stall, a long hold-off on request, or at random
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            stall_left = PRESSURE_CYCLES;
            rsp_tready <= 1'b0;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(20, 60);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Watchdog: end the run when no word moves for too long
   // ---------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Sequencer: bounds phases and the beats for each
   // ---------------------------------------------------------------
   task automatic write_csr(logic [7:0] index, logic [7:0] value);
      @(posedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // indexes beyond the two bounds are dropped by the block
      if (index == CSR_RATE_FLOOR) floor_bpm = value;
      else if (index == CSR_RATE_CEILING) ceiling_bpm = value;
   endtask

   task automatic set_bounds(logic [7:0] lo, logic [7:0] hi);
      write_csr(CSR_RATE_FLOOR, lo);
      write_csr(CSR_RATE_CEILING, hi);
   endtask

   // wait until every queued beat has come back, then let the block settle;
   // sample between edges so the driver and monitor have settled
   task automatic drain();
      do @(negedge clock);
      while (beat_times_q.size() > 0 || req_tvalid || expected_rates.size() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [7:0] lo_pick;
      floor_bpm = RATE_FLOOR_RESET;
      ceiling_bpm = RATE_CEILING_RESET;
      last_beat = '0;
      foreach (rate_ring[k]) rate_ring[k] = '0;
      ring_slot = 0;
      held_avg = '0;
      gen_prev = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset bounds: first beat measured from zero gives a zero interval
      queue_after(0);
      queue_after(1000);          // 60 bpm into a ring still holding zeros
      queue_after(500);
      queue_after(500);
      queue_after(800);
      queue_after(1);             // rate far above 255, saturated
      queue_after(100);
      queue_after(235);           // just above the ceiling
      queue_after(240);           // exactly the ceiling, rejected
      queue_after(241);
      queue_after(3000);          // exactly the floor, rejected
      queue_after(2999);          // a hair above the floor, stored as the floor
      queue_at(32'hFFFF_FE00);    // huge interval, rate zero
      queue_at(32'hFFFF_FFFF);
      queue_at(32'h0000_02E7);    // interval wraps through zero
      drain();

      // Widest bounds: a zero rate and a rate of one both pass
      set_bounds(8'd0, 8'd255);
      queue_after(60001);
      queue_after(60000);
      queue_after(236);
      queue_after(235);           // 255 bpm, not below a ceiling of 255
      drain();

      // Narrow and inverted bounds, then a write to an unused index
      set_bounds(8'd100, 8'd101);
      queue_after(600);
      queue_after(595);           // fractional rate slips between the bounds
      drain();
      set_bounds(8'd255, 8'd0);
      queue_after(1000);
      drain();
      write_csr(CSR_SPARE, 8'hFF);
      queue_after(1000);
      drain();

      // Back-pressure: hold the receiver off while beats keep coming
      set_bounds(RATE_FLOOR_RESET, RATE_CEILING_RESET);
      steady = 1'b1;
      hold_req = 1'b1;
      queue_random(12);
      drain();
      steady = 1'b0;

      // Random beats under a series of bound settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_bounds(RATE_FLOOR_RESET, RATE_CEILING_RESET);
            1: set_bounds(8'd0, 8'd255);
            2: begin
               set_bounds(8'd40, 8'd180);
               steady = 1'b1;
            end
            3: begin
               lo_pick = 8'($urandom_range(0, 150));
               set_bounds(lo_pick, 8'($urandom_range(lo_pick + 1, 255)));
            end
            4: set_bounds(8'($urandom()), 8'($urandom()));
            default: set_bounds(8'd60, 8'd100);
         endcase
         queue_random(85);
         drain();
         steady = 1'b0;
      end

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
hdl/bira_pkg.sv
hdl/bira_divider.sv
hdl/bira_ring.sv
hdl/beat_interval_rate_averager.sv
dv/beat_interval_rate_averager_test.sv
